[hdl/aqg_pkg.sv]
// Shared types, constants and helper functions for the quadrilateral geometry pipeline.
package aqg_pkg;

   // CORDIC iteration count (8 to 24); the pipeline depth follows from it.
   localparam int CORDIC_STEPS = 16;

   // Widths of difference vectors, CORDIC datapath, angles, magnitudes and angle errors.
   localparam int DW = 18;
   localparam int CW = 30;
   localparam int AW = 21;
   localparam int MW = 28;
   localparam int EW = 23;

   // Vectors are scaled by 2^PRESCALE_SH before the CORDIC iterations.
   localparam int PRESCALE_SH = 8;

   // The ratio is Q8.8, so the dividend is the larger horizontal length shifted by RATIO_SH.
   localparam int RATIO_SH = 8;
   localparam int DIV_STEPS = 16;

   // Angle constants in Q16 radians.
   localparam logic signed [AW-1:0] PI_Q16      = AW'(205887);
   localparam logic signed [AW-1:0] HALF_PI_Q16 = AW'(102944);

   // Pipeline stage positions.
   localparam int ST_CORDIC_LAST = CORDIC_STEPS + 1;
   localparam int ST_A           = CORDIC_STEPS + 2;
   localparam int ST_B           = CORDIC_STEPS + 3;
   localparam int ST_D0          = CORDIC_STEPS + 4;
   localparam int NSTG           = ST_D0 + DIV_STEPS;

   // Vector lanes feeding the CORDIC units.
   localparam int V_LW    = 0;
   localparam int V_RW    = 1;
   localparam int V_TL    = 2;
   localparam int V_BL    = 3;
   localparam int V_ROLL  = 4;
   localparam int V_LEFT  = 5;
   localparam int V_RIGHT = 6;
   localparam int NVEC    = 7;

   typedef struct packed {
      logic signed [15:0] top_left_x;
      logic signed [15:0] top_left_y;
      logic signed [15:0] top_right_x;
      logic signed [15:0] top_right_y;
      logic signed [15:0] bottom_right_x;
      logic signed [15:0] bottom_right_y;
      logic signed [15:0] bottom_left_x;
      logic signed [15:0] bottom_left_y;
   } req_type;

   typedef struct packed {
      logic signed [15:0] center_x;
      logic signed [15:0] center_y;
      logic [15:0]        aspect_ratio;
      logic [15:0]        rect_error;
      logic               degenerate;
   } rsp_type;

   // Values that travel alongside the arithmetic through the pipeline.
   typedef struct packed {
      logic signed [15:0] cx;
      logic signed [15:0] cy;
      logic               zero_roll;
      logic               zero_left;
      logic               zero_right;
      logic [15:0]        err;
      logic               ovf;
   } side_type;

   // Arctangent of 2^-idx in Q16 radians, rounded to nearest.
   function automatic logic signed [AW-1:0] atan_q16(input int idx);
      logic signed [AW-1:0] r;
      case (idx)
         0:  r = AW'(51472);
         1:  r = AW'(30386);
         2:  r = AW'(16055);
         3:  r = AW'(8150);
         4:  r = AW'(4091);
         5:  r = AW'(2047);
         6:  r = AW'(1024);
         7:  r = AW'(512);
         8:  r = AW'(256);
         9:  r = AW'(128);
         10: r = AW'(64);
         11: r = AW'(32);
         12: r = AW'(16);
         13: r = AW'(8);
         14: r = AW'(4);
         15: r = AW'(2);
         16: r = AW'(1);
         default: r = '0;
      endcase
      return r;
   endfunction

   // Sign extension of a 16-bit coordinate to the difference width.
   function automatic logic signed [DW-1:0] ext16(input logic signed [15:0] v);
      return DW'(v);
   endfunction

endpackage

[hdl/armor_quad_geometry.sv]
// Top level of the quadrilateral geometry pipeline: centre, aspect ratio and rectangularity.
// Throughput: one item per cycle while the skid is free; all stages advance on one enable.
// A two-entry output register (main plus skid) lets the pipeline run while a result waits.
// Reset clears all valid bits, including those of the output registers; payload registers
// are not reset.
module armor_quad_geometry import aqg_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   logic en;
   logic v_ff [0:NSTG-1];
   side_type side_ff [0:NSTG-1];
   side_type side_in [0:NSTG-1];

   logic signed [DW-1:0] vx_ff [0:NVEC-1];
   logic signed [DW-1:0] vy_ff [0:NVEC-1];
   logic signed [DW-1:0] vx_in [0:NVEC-1];
   logic signed [DW-1:0] vy_in [0:NVEC-1];

   logic [MW-1:0]        mag [0:NVEC-1];
   logic signed [AW-1:0] ang [0:NVEC-1];

   logic signed [DW-1:0] x0, y0, x1, y1, x2, y2, x3, y3;
   logic signed [DW-1:0] sum_x, sum_y;

   logic [MW-1:0] vmax_a_ff, hmax_a_ff;
   logic [EW-1:0] le_ff, re_ff;
   logic [MW-1:0] vmax_in, hmax_in;
   logic [EW-1:0] le_in, re_in;

   logic [MW-1:0]        rem_b_ff, vmax_b_ff;
   logic [DIV_STEPS-1:0] nb_b_ff;
   logic [15:0]          err_in;
   logic                 ovf_in;
   logic [DIV_STEPS-1:0] quo;

   rsp_type res, main_ff, skid_ff;
   logic    main_v_ff, skid_v_ff;

   // The pipeline moves whenever the skid entry is free.
   assign en        = !skid_v_ff;
   assign req_ready = en;

   // Input stage: edge vectors, the left-to-right midpoint vector and the centre.
   always_comb begin
      x0 = ext16(req_data.top_left_x);
      y0 = ext16(req_data.top_left_y);
      x1 = ext16(req_data.top_right_x);
      y1 = ext16(req_data.top_right_y);
      x2 = ext16(req_data.bottom_right_x);
      y2 = ext16(req_data.bottom_right_y);
      x3 = ext16(req_data.bottom_left_x);
      y3 = ext16(req_data.bottom_left_y);
      vx_in[V_LW]    = x0 - x3;
      vy_in[V_LW]    = y0 - y3;
      vx_in[V_RW]    = x1 - x2;
      vy_in[V_RW]    = y1 - y2;
      vx_in[V_TL]    = x0 - x1;
      vy_in[V_TL]    = y0 - y1;
      vx_in[V_BL]    = x3 - x2;
      vy_in[V_BL]    = y3 - y2;
      vx_in[V_ROLL]  = (x1 + x2) - (x0 + x3);
      vy_in[V_ROLL]  = (y1 + y2) - (y0 + y3);
      vx_in[V_LEFT]  = x3 - x0;
      vy_in[V_LEFT]  = y3 - y0;
      vx_in[V_RIGHT] = x2 - x1;
      vy_in[V_RIGHT] = y2 - y1;
      sum_x = x0 + x1 + x2 + x3;
      sum_y = y0 + y1 + y2 + y3;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NVEC; i++) begin
            vx_ff[i] <= vx_in[i];
            vy_ff[i] <= vy_in[i];
         end
      end
   end

   // One CORDIC unit for each vector.
   for (genvar g = 0; g < NVEC; g++) begin : g_cordic
      aqg_cordic u_cordic (
         .clock (clock),
         .en    (en),
         .vec_x (vx_ff[g]),
         .vec_y (vy_ff[g]),
         .mag   (mag[g]),
         .ang   (ang[g])
      );
   end

   // Stage A: longest edges and the two side-angle deviations.
   always_comb begin
      logic signed [EW-1:0] al, ar, ro, dl, dr;
      vmax_in = (mag[V_LW] > mag[V_RW]) ? mag[V_LW] : mag[V_RW];
      hmax_in = (mag[V_TL] > mag[V_BL]) ? mag[V_TL] : mag[V_BL];
      al = side_ff[ST_CORDIC_LAST].zero_left  ? '0 : EW'(ang[V_LEFT]);
      ar = side_ff[ST_CORDIC_LAST].zero_right ? '0 : EW'(ang[V_RIGHT]);
      ro = side_ff[ST_CORDIC_LAST].zero_roll  ? '0 : EW'(ang[V_ROLL]);
      dl = al - ro - EW'(HALF_PI_Q16);
      dr = ar - ro - EW'(HALF_PI_Q16);
      le_in = dl[EW-1] ? $unsigned(-dl) : $unsigned(dl);
      re_in = dr[EW-1] ? $unsigned(-dr) : $unsigned(dr);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vmax_a_ff <= vmax_in;
         hmax_a_ff <= hmax_in;
         le_ff     <= le_in;
         re_ff     <= re_in;
      end
   end

   // Stage B: round the error to Q4.12, detect ratio overflow and set up the divider.
   always_comb begin
      logic [EW-1:0] m, r;
      m = (le_ff > re_ff) ? le_ff : re_ff;
      r = (m + EW'(8)) >> 4;
      err_in = (r > EW'(16'hFFFF)) ? 16'hFFFF : r[15:0];
      ovf_in = {8'b0, hmax_a_ff, {RATIO_SH{1'b0}}} >= {vmax_a_ff, {DIV_STEPS{1'b0}}};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_b_ff  <= hmax_a_ff >> RATIO_SH;
         nb_b_ff   <= {hmax_a_ff[RATIO_SH-1:0], {(DIV_STEPS-RATIO_SH){1'b0}}};
         vmax_b_ff <= vmax_a_ff;
      end
   end

   aqg_div u_div (
      .clock   (clock),
      .en      (en),
      .rem_in  (rem_b_ff),
      .bits_in (nb_b_ff),
      .div_in  (vmax_b_ff),
      .quo     (quo)
   );

   // Side values shift along with the arithmetic; stage B fills in error and overflow.
   always_comb begin
      side_in[0].cx         = sum_x[17:2];
      side_in[0].cy         = sum_y[17:2];
      side_in[0].zero_roll  = (vx_in[V_ROLL] == '0) && (vy_in[V_ROLL] == '0);
      side_in[0].zero_left  = (vx_in[V_LEFT] == '0) && (vy_in[V_LEFT] == '0);
      side_in[0].zero_right = (vx_in[V_RIGHT] == '0) && (vy_in[V_RIGHT] == '0);
      side_in[0].err        = '0;
      side_in[0].ovf        = 1'b0;
      for (int i = 1; i < NSTG; i++) begin
         side_in[i] = side_ff[i-1];
      end
      side_in[ST_B].err = err_in;
      side_in[ST_B].ovf = ovf_in;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < NSTG; i++) begin
            side_ff[i] <= side_in[i];
         end
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NSTG; i++) begin
            v_ff[i] <= 1'b0;
         end
      end else if (en) begin
         v_ff[0] <= req_valid;
         for (int i = 1; i < NSTG; i++) begin
            v_ff[i] <= v_ff[i-1];
         end
      end
   end

   // Final formatting of the result item.
   always_comb begin
      res.center_x     = side_ff[NSTG-1].cx;
      res.center_y     = side_ff[NSTG-1].cy;
      res.aspect_ratio = side_ff[NSTG-1].ovf ? 16'hFFFF : quo;
      res.rect_error   = side_ff[NSTG-1].err;
      res.degenerate   = side_ff[NSTG-1].ovf;
   end

   // Output register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_v_ff <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (skid_v_ff) begin
         if (rsp_ready) begin
            main_ff   <= skid_ff;
            skid_v_ff <= 1'b0;
         end
      end else if (!main_v_ff || rsp_ready) begin
         main_v_ff <= v_ff[NSTG-1];
         if (v_ff[NSTG-1]) begin
            main_ff <= res;
         end
      end else if (v_ff[NSTG-1]) begin
         skid_ff   <= res;
         skid_v_ff <= 1'b1;
      end
   end

   assign rsp_valid = main_v_ff;
   assign rsp_data  = main_ff;

endmodule

[hdl/aqg_cordic.sv]
// Pipelined vectoring CORDIC: one register stage per iteration plus a pre-rotation stage.
module aqg_cordic import aqg_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic signed [DW-1:0] vec_x,
   input  logic signed [DW-1:0] vec_y,
   output logic [MW-1:0]        mag,
   output logic signed [AW-1:0] ang
);

   logic signed [CW-1:0] x_ff [0:CORDIC_STEPS];
   logic signed [CW-1:0] y_ff [0:CORDIC_STEPS];
   logic signed [AW-1:0] z_ff [0:CORDIC_STEPS];

   logic signed [CW-1:0] px, py;
   logic signed [CW-1:0] x_in, y_in;
   logic signed [AW-1:0] z_in;

   // Scale the vector, then fold the left half-plane into the right one.
   always_comb begin
      px = $signed({{(CW-DW-PRESCALE_SH){vec_x[DW-1]}}, vec_x, {PRESCALE_SH{1'b0}}});
      py = $signed({{(CW-DW-PRESCALE_SH){vec_y[DW-1]}}, vec_y, {PRESCALE_SH{1'b0}}});
      if (vec_x[DW-1]) begin
         x_in = -px;
         y_in = -py;
         z_in = vec_y[DW-1] ? -PI_Q16 : PI_Q16;
      end else begin
         x_in = px;
         y_in = py;
         z_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff[0] <= x_in;
         y_ff[0] <= y_in;
         z_ff[0] <= z_in;
      end
   end

   // One micro-rotation per stage, driving y towards zero.
   for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_step
      always_ff @(posedge clock) begin
         if (en) begin
            if (!y_ff[g][CW-1]) begin
               x_ff[g+1] <= x_ff[g] + (y_ff[g] >>> g);
               y_ff[g+1] <= y_ff[g] - (x_ff[g] >>> g);
               z_ff[g+1] <= z_ff[g] + atan_q16(g);
            end else begin
               x_ff[g+1] <= x_ff[g] - (y_ff[g] >>> g);
               y_ff[g+1] <= y_ff[g] + (x_ff[g] >>> g);
               z_ff[g+1] <= z_ff[g] - atan_q16(g);
            end
         end
      end
   end

   assign mag = x_ff[CORDIC_STEPS][MW-1:0];
   assign ang = z_ff[CORDIC_STEPS];

endmodule

[hdl/aqg_div.sv]
// Pipelined restoring divider producing one quotient bit per stage.
module aqg_div import aqg_pkg::*; (
   input  logic                 clock,
   input  logic                 en,
   input  logic [MW-1:0]        rem_in,
   input  logic [DIV_STEPS-1:0] bits_in,
   input  logic [MW-1:0]        div_in,
   output logic [DIV_STEPS-1:0] quo
);

   logic [MW-1:0]        r_ff  [0:DIV_STEPS-1];
   logic [DIV_STEPS-1:0] nb_ff [0:DIV_STEPS-1];
   logic [DIV_STEPS-1:0] q_ff  [0:DIV_STEPS-1];
   logic [MW-1:0]        d_ff  [0:DIV_STEPS-1];

   logic [MW-1:0]        r_cur  [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] nb_cur [0:DIV_STEPS];
   logic [DIV_STEPS-1:0] q_cur  [0:DIV_STEPS];
   logic [MW-1:0]        d_cur  [0:DIV_STEPS];

   assign r_cur[0]  = rem_in;
   assign nb_cur[0] = bits_in;
   assign q_cur[0]  = '0;
   assign d_cur[0]  = div_in;

   for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
      logic [MW:0] trial;

      // Bring down the next dividend bit and subtract the divisor where it fits.
      assign trial = {r_cur[g], nb_cur[g][DIV_STEPS-1]};

      always_ff @(posedge clock) begin
         if (en) begin
            if (trial >= {1'b0, d_cur[g]}) begin
               r_ff[g] <= MW'(trial - {1'b0, d_cur[g]});
               q_ff[g] <= {q_cur[g][DIV_STEPS-2:0], 1'b1};
            end else begin
               r_ff[g] <= trial[MW-1:0];
               q_ff[g] <= {q_cur[g][DIV_STEPS-2:0], 1'b0};
            end
            nb_ff[g] <= {nb_cur[g][DIV_STEPS-2:0], 1'b0};
            d_ff[g]  <= d_cur[g];
         end
      end

      assign r_cur[g+1]  = r_ff[g];
      assign nb_cur[g+1] = nb_ff[g];
      assign q_cur[g+1]  = q_ff[g];
      assign d_cur[g+1]  = d_ff[g];
   end

   assign quo = q_cur[DIV_STEPS];

endmodule

[hdl/aqg_checker.sv]
// Port-level checker for the quadrilateral geometry block, bound to its top level.
module aqg_checker import aqg_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_ready,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // A result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result item changed while stalled");

   // No result shows straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A degenerate item always carries the saturated ratio.
   a_degen_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.degenerate |-> rsp_data.aspect_ratio == 16'hFFFF)
      else $error("degenerate item without saturated ratio");

   // Input back-pressure only arises while a result is waiting.
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with no pending result");

endmodule

bind armor_quad_geometry aqg_checker u_aqg_checker (.*);

[tb/armor_quad_geometry_tb.sv]
// Self-checking testbench for the quadrilateral geometry pipeline.
module armor_quad_geometry_tb;
   import aqg_pkg::*;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   rsp_type geometry_due[$];
   int      mismatch_count = 0;
   bit      stall_heavy = 1'b0;

   armor_quad_geometry dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   // Vectoring CORDIC: returns the gain-scaled magnitude and the Q16 angle.
   function automatic void vector_polar(input longint vx, input longint vy,
                                        output longint mag, output longint ang);
      longint x, y, z, dx, dy;
      x = vx * 256;
      y = vy * 256;
      z = 0;
      if (vx == 0 && vy == 0) begin
         mag = 0;
         ang = 0;
         return;
      end
      if (x < 0) begin
         z = (y >= 0) ? 205887 : -205887;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         dx = x >>> i;
         dy = y >>> i;
         if (y >= 0) begin
            x = x + dy;
            y = y - dx;
            z = z + longint'(atan_q16(i));
         end else begin
            x = x - dy;
            y = y + dx;
            z = z - longint'(atan_q16(i));
         end
      end
      mag = x;
      ang = z;
   endfunction

   // Works out centre, aspect ratio, rectangularity error and the degenerate flag.
   function automatic rsp_type quad_geometry(input req_type q);
      longint x0, y0, x1, y1, x2, y2, x3, y3;
      longint lw, rw, tw, bw, dummy, roll, al, ar, vmax, hmax, ratio, le, re, err;
      rsp_type r;
      x0 = q.top_left_x;     y0 = q.top_left_y;
      x1 = q.top_right_x;    y1 = q.top_right_y;
      x2 = q.bottom_right_x; y2 = q.bottom_right_y;
      x3 = q.bottom_left_x;  y3 = q.bottom_left_y;
      r.center_x = 16'((x0 + x1 + x2 + x3) >>> 2);
      r.center_y = 16'((y0 + y1 + y2 + y3) >>> 2);
      vector_polar(x0 - x3, y0 - y3, lw, dummy);
      vector_polar(x1 - x2, y1 - y2, rw, dummy);
      vector_polar(x0 - x1, y0 - y1, tw, dummy);
      vector_polar(x3 - x2, y3 - y2, bw, dummy);
      vmax = lw > rw ? lw : rw;
      hmax = tw > bw ? tw : bw;
      r.degenerate = 1'b0;
      if (vmax == 0) begin
         ratio = 65535;
         r.degenerate = 1'b1;
      end else begin
         ratio = (hmax * 256) / vmax;
         if (ratio > 65535) begin
            ratio = 65535;
            r.degenerate = 1'b1;
         end
      end
      r.aspect_ratio = 16'(ratio);
      vector_polar((x1 + x2) - (x0 + x3), (y1 + y2) - (y0 + y3), dummy, roll);
      vector_polar(x3 - x0, y3 - y0, dummy, al);
      vector_polar(x2 - x1, y2 - y1, dummy, ar);
      le = al - roll - 102944;
      re = ar - roll - 102944;
      if (le < 0) le = -le;
      if (re < 0) re = -re;
      err = le > re ? le : re;
      err = (err + 8) >>> 4;
      if (err > 65535) err = 65535;
      r.rect_error = 16'(err);
      return r;
   endfunction

   // Sends one item and records its expected result once accepted; valid stays up
   // so that the next item can follow straight away.
   task automatic send_quad(input req_type q);
      req_valid <= 1'b1;
      req_data  <= q;
      do @(posedge clock); while (!req_ready);
      geometry_due.push_back(quad_geometry(q));
      @(negedge clock);
   endtask

   // Sender gap of random length, sometimes none.
   task automatic maybe_gap();
      if ($urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   // Receiver stall pattern: phases of steady acceptance and phases of heavy stalling.
   always @(negedge clock) begin
      if ($urandom_range(0, 99) == 0) stall_heavy <= ~stall_heavy;
      rsp_ready <= stall_heavy ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (geometry_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result item %p", rsp_data);
         end else begin
            want = geometry_due.pop_front();
            if (rsp_data !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: expected %p, got %p", want, rsp_data);
            end
         end
      end
   end

   function automatic req_type quad_of(input logic [15:0] a, b, c, d, e, f, g, h);
      quad_of = {a, b, c, d, e, f, g, h};
   endfunction

   // Directed corners: extremes, zero edges, saturation and wrapped angles.
   task automatic test_directed();
      send_quad('0);
      send_quad({8{16'h7fff}});
      send_quad({8{16'h8000}});
      send_quad(quad_of(16'h8000, 16'h8000, 16'h7fff, 16'h8000,
                        16'h7fff, 16'h7fff, 16'h8000, 16'h7fff));
      send_quad(quad_of(16'h7fff, 16'h7fff, 16'h8000, 16'h7fff,
                        16'h8000, 16'h8000, 16'h7fff, 16'h8000));
      send_quad(quad_of(0, 0, 100, 0, 100, 50, 0, 50));
      send_quad(quad_of(0, 0, 16'h7fff, 0, 16'h7fff, 0, 0, 0));
      send_quad(quad_of(16'h8000, 0, 16'h7fff, 0, 16'h7fff, 1, 16'h8000, 1));
      send_quad(quad_of(0, 0, 0, 0, 0, 100, 0, 100));
      send_quad(quad_of(0, 0, 10, 0, 10, 0, 0, 0));
      send_quad(quad_of(100, 0, 0, 0, 0, 50, 100, 50));
      send_quad(quad_of(0, 50, 100, 50, 100, 0, 0, 0));
      send_quad(quad_of(0, 0, 100, 16'hff9c, 200, 0, 100, 100));
      send_quad(quad_of(0, 0, 16'hfffb, 0, 16'hfffb, 0, 0, 16'hffff));
      send_quad(quad_of(16'hffff, 16'hffff, 16'hffff, 16'hffff, 1, 1, 1, 1));
      send_quad(quad_of(16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
                        16'h5555, 16'haaaa, 16'haaaa, 16'h5555));
   endtask

   // Random quadrilaterals: mostly plausible boxes, some wide open noise.
   task automatic test_random(input int count);
      req_type q;
      int cx, cy, w, h, j;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            q = {$urandom, $urandom, $urandom, $urandom};
         end else begin
            cx = $urandom_range(0, 30000) - 15000;
            cy = $urandom_range(0, 30000) - 15000;
            w  = $urandom_range(0, 2000);
            h  = $urandom_range(0, 1000);
            j  = $urandom_range(0, 40);
            q.top_left_x     = 16'(cx - w + $urandom_range(0, j));
            q.top_left_y     = 16'(cy - h + $urandom_range(0, j));
            q.top_right_x    = 16'(cx + w - $urandom_range(0, j));
            q.top_right_y    = 16'(cy - h + $urandom_range(0, j));
            q.bottom_right_x = 16'(cx + w - $urandom_range(0, j));
            q.bottom_right_y = 16'(cy + h - $urandom_range(0, j));
            q.bottom_left_x  = 16'(cx - w + $urandom_range(0, j));
            q.bottom_left_y  = 16'(cy + h - $urandom_range(0, j));
         end
         send_quad(q);
         // Bursts: most items go back to back, then an occasional gap.
         maybe_gap();
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(1950);
      if (req_valid) req_valid <= 1'b0;
      while (geometry_due.size() != 0) @(posedge clock);
      repeat (CORDIC_STEPS + 40) @(posedge clock);
      if (mismatch_count == 0 && geometry_due.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #4000000;
      $display("FAILURE");
      $finish;
   end

endmodule

[sim.f]
hdl/aqg_pkg.sv
hdl/aqg_cordic.sv
hdl/aqg_div.sv
hdl/armor_quad_geometry.sv
hdl/aqg_checker.sv
tb/armor_quad_geometry_tb.sv
